/* src/kwsm_pkg.sv */
// ----------------------------------------------------------------------------
// kwsm_pkg
// shared constants, codes and types of the k-way sorted merge core
// ----------------------------------------------------------------------------
package kwsm_pkg;

  localparam int LANES      = 8;
  localparam int LANE_DEPTH = 16;

  localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int PTR_W   = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(LANE_DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = LANE_W + PTR_W;
  localparam int WORDS   = LANES * LANE_DEPTH;

  // widths of the external fields
  localparam int IN_LANE_W  = 3;
  localparam int OUT_LANE_W = 3;
  localparam int STATUS_W   = 2;

  typedef logic [LANE_W-1:0]     lane_idx_t;
  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [DATA_W-1:0]     data_t;
  typedef logic [OUT_LANE_W-1:0] out_lane_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // head candidate offered to the compare unit
  typedef struct packed {
    logic      vld;
    lane_idx_t lane;
  } cand_t;

  // running minimum kept by the compare unit
  typedef struct packed {
    logic      found;
    lane_idx_t lane;
    data_t     value;
  } best_t;

  function automatic ptr_t next_slot(input ptr_t slot);
    ptr_t res;
    if (slot == ptr_t'(LANE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = slot + ptr_t'(1);
    end
    return res;
  endfunction

endpackage

/* src/k_way_sorted_merge_core.sv */
// ----------------------------------------------------------------------------
// k_way_sorted_merge_core
// k-way merge of sorted lanes: push words into per-lane fifos, pop the
// smallest head across all lanes
// ----------------------------------------------------------------------------
// The core holds LANES fifos of LANE_DEPTH signed 32-bit words in one shared
// storage array. A push word (op 0) appends value to its lane and answers
// status 0, or status 1 when the lane is full or out of range. A pop word
// (op 1) returns the smallest head of all nonempty lanes with its lane
// number and status 2; a tie goes to the lowest lane; with every lane empty
// it answers status 3 and zeros. One word is in flight at a time: in_ready is
// low from the accepting edge until the result is loaded into the output
// register. out_valid rises once a push has passed S_PUSH and S_DONE, and
// once a pop has passed S_SCAN, S_DRAIN, S_COMMIT and S_DONE; the single
// comparator visits one lane head per cycle behind the registered read
// of the storage array. The next word is accepted the cycle after the result
// is loaded, even while the previous result still waits on out_ready, so a
// push occupies the core through S_PUSH and S_DONE and a pop through S_SCAN,
// S_DRAIN, S_COMMIT and S_DONE; S_DONE waits while an earlier result is
// held up by out_ready. The storage needs no clearing after reset: only
// entries that a push wrote are ever read.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // input words
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  op,
  input  logic [kwsm_pkg::IN_LANE_W-1:0]        lane,
  input  logic signed [kwsm_pkg::DATA_W-1:0]    value,
  // result words
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [kwsm_pkg::STATUS_W-1:0]         status,
  output logic signed [kwsm_pkg::DATA_W-1:0]    out_value,
  output logic [kwsm_pkg::OUT_LANE_W-1:0]       out_lane
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_DONE
  } state_t;

  state_t state;

  // per-lane bookkeeping
  kwsm_pkg::ptr_t rd_ptr [kwsm_pkg::LANES];
  kwsm_pkg::ptr_t wr_ptr [kwsm_pkg::LANES];
  kwsm_pkg::cnt_t fill   [kwsm_pkg::LANES];

  // captured input word
  kwsm_pkg::lane_idx_t lane_q;
  logic                lane_ok_q;
  kwsm_pkg::data_t     value_q;

  // scan sequencer
  kwsm_pkg::lane_idx_t scan_idx;
  kwsm_pkg::cand_t     cand;

  // pending result
  kwsm_pkg::status_t   res_status;
  kwsm_pkg::data_t     res_value;
  kwsm_pkg::out_lane_t res_lane;

  // datapath
  kwsm_pkg::best_t     best;
  kwsm_pkg::data_t     rd_data;
  kwsm_pkg::lane_idx_t sel_lane;
  kwsm_pkg::ptr_t      sel_rd_ptr;
  kwsm_pkg::ptr_t      sel_wr_ptr;
  kwsm_pkg::cnt_t      sel_fill;
  logic                in_fire;
  logic                out_fire;
  logic                push_ok;
  logic                mem_wr_en;
  logic                mem_rd_en;
  logic                min_clear;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // one lane of bookkeeping is looked at per cycle, picked by the state
  always_comb begin
    unique case (state)
      S_PUSH:   sel_lane = lane_q;
      S_SCAN:   sel_lane = scan_idx;
      S_COMMIT: sel_lane = best.lane;
      default:  sel_lane = '0;
    endcase
  end

  assign sel_rd_ptr = rd_ptr[sel_lane];
  assign sel_wr_ptr = wr_ptr[sel_lane];
  assign sel_fill   = fill[sel_lane];

  assign push_ok   = lane_ok_q && (sel_fill < kwsm_pkg::cnt_t'(kwsm_pkg::LANE_DEPTH));
  assign mem_wr_en = (state == S_PUSH) && push_ok;
  // skip the read for an empty lane: its head slot may never have been written
  assign mem_rd_en = (state == S_SCAN) && (sel_fill != '0);
  assign min_clear = in_fire;

  kwsm_store u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr ({lane_q, sel_wr_ptr}),
    .wr_data (value_q),
    .rd_en   (mem_rd_en),
    .rd_addr ({scan_idx, sel_rd_ptr}),
    .rd_data (rd_data)
  );

  kwsm_min u_min (
    .clk        (clk),
    .rst        (rst),
    .clear      (min_clear),
    .cand       (cand),
    .cand_value (rd_data),
    .best       (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      scan_idx  <= '0;
      cand      <= '0;
      for (int i = 0; i < kwsm_pkg::LANES; i++) begin
        rd_ptr[i] <= '0;
        wr_ptr[i] <= '0;
        fill[i]   <= '0;
      end
    end else begin
      if (out_fire) begin
        out_valid <= 1'b0;
      end

      // head candidate lines up with the registered storage read
      cand.vld  <= mem_rd_en;
      cand.lane <= scan_idx;

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            lane_q    <= kwsm_pkg::lane_idx_t'(lane);
            lane_ok_q <= (32'(lane) < kwsm_pkg::LANES);
            value_q   <= value;
            scan_idx  <= '0;
            state     <= (op == kwsm_pkg::OP_POP) ? S_SCAN : S_PUSH;
          end
        end

        S_PUSH: begin
          res_value <= '0;
          res_lane  <= '0;
          if (push_ok) begin
            wr_ptr[sel_lane] <= kwsm_pkg::next_slot(sel_wr_ptr);
            fill[sel_lane]   <= sel_fill + kwsm_pkg::cnt_t'(1);
            res_status       <= kwsm_pkg::ST_PUSHED;
          end else begin
            res_status       <= kwsm_pkg::ST_FULL;
          end
          state <= S_DONE;
        end

        S_SCAN: begin
          scan_idx <= scan_idx + kwsm_pkg::lane_idx_t'(1);
          if (scan_idx == kwsm_pkg::lane_idx_t'(kwsm_pkg::LANES - 1)) begin
            state <= S_DRAIN;
          end
        end

        // last head is compared in this cycle
        S_DRAIN: begin
          state <= S_COMMIT;
        end

        S_COMMIT: begin
          if (best.found) begin
            rd_ptr[sel_lane] <= kwsm_pkg::next_slot(sel_rd_ptr);
            fill[sel_lane]   <= sel_fill - kwsm_pkg::cnt_t'(1);
            res_status       <= kwsm_pkg::ST_POPPED;
            res_value        <= best.value;
            res_lane         <= kwsm_pkg::out_lane_t'(best.lane);
          end else begin
            res_status       <= kwsm_pkg::ST_EMPTY;
            res_value        <= '0;
            res_lane         <= '0;
          end
          state <= S_DONE;
        end

        // load the output register once the previous result has left
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res_status;
            out_value <= res_value;
            out_lane  <= res_lane;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // only a successful pop carries a value and a lane
  a_nonpop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != kwsm_pkg::ST_POPPED) |-> (out_value == '0) && (out_lane == '0))
    else $error("nonzero payload on a result that is not a pop");

  // one word at a time: no acceptance in the cycle after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // a lane picked by the scan must hold at least one word
  a_pick_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) && best.found |-> (sel_fill != '0))
    else $error("pop picked an empty lane");

  // the lane under selection never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    sel_fill <= kwsm_pkg::cnt_t'(kwsm_pkg::LANE_DEPTH))
    else $error("lane fill count beyond depth");

endmodule

/* src/kwsm_store.sv */
// ----------------------------------------------------------------------------
// kwsm_store
// lane element storage: one write port, one registered read port
// ----------------------------------------------------------------------------
module kwsm_store (
  input  logic            clk,
  input  logic            wr_en,
  input  kwsm_pkg::addr_t wr_addr,
  input  kwsm_pkg::data_t wr_data,
  input  logic            rd_en,
  input  kwsm_pkg::addr_t rd_addr,
  output kwsm_pkg::data_t rd_data
);

  kwsm_pkg::data_t mem [kwsm_pkg::WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/kwsm_min.sv */
// ----------------------------------------------------------------------------
// kwsm_min
// shared signed comparator that keeps the smallest head seen during a scan
// ----------------------------------------------------------------------------
module kwsm_min (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  kwsm_pkg::cand_t cand,
  input  kwsm_pkg::data_t cand_value,
  output kwsm_pkg::best_t best
);

  logic take;

  // strict less-than: on a tie the earlier (lower) lane stays
  assign take = cand.vld && (!best.found || ($signed(cand_value) < $signed(best.value)));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best.found <= 1'b0;
      best.lane  <= '0;
      best.value <= '0;
    end else if (take) begin
      best.found <= 1'b1;
      best.lane  <= cand.lane;
      best.value <= cand_value;
    end
  end

endmodule
